// ===== src/bds_pkg.sv =====
package bds_pkg;

    localparam int BOX_W = 64;
    localparam logic [15:0] TOL_RESET = 16'd80;   // 5.0 pixels

    typedef struct packed {
        logic               first_of_group;
        logic signed [15:0] corner1_x;
        logic signed [15:0] corner1_y;
        logic signed [15:0] corner2_x;
        logic signed [15:0] corner2_y;
        logic        [7:0]  class_id;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_corner1_x;
        logic signed [15:0] out_corner1_y;
        logic signed [15:0] out_corner2_x;
        logic signed [15:0] out_corner2_y;
        logic        [7:0]  out_class_id;
        logic               not_stored;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } bds_state_t;

    typedef struct packed {
        logic latch;        // take the input item, start a new scan
        logic rd_en;        // read the next kept entry
        logic store_emit;   // load the output register, append if room
    } bds_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_issued;
        logic pipe_empty;
        logic hit;
        logic out_free;
    } bds_status_t;

endpackage

// ===== src/bds_ctrl.sv =====
module bds_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bds_pkg::bds_status_t status,
    output bds_pkg::bds_cmd_t    cmd
);
    import bds_pkg::*;

    bds_state_t state_reg;
    bds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                // empty table or new group: nothing to compare against
                if (status.count_zero)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_issued)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // wait for the last compare, then drop or emit
                if (status.pipe_empty)
                    state_next = status.hit ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.store_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !status.count_zero)
        else $error("scan started on an empty table");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && $past(state_reg) == ST_SCAN) |-> !status.pipe_empty)
        else $error("last read lost before its compare");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one command in a cycle");
`endif

endmodule

// ===== src/bds_dpath.sv =====
module bds_dpath #(
    parameter int MAX_KEPT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  bds_pkg::in_item_t    in_data,
    input  bds_pkg::bds_cmd_t    cmd,
    output bds_pkg::bds_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bds_pkg::out_item_t   out_data
);
    import bds_pkg::*;

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    logic [BOX_W-1:0] mem [MAX_KEPT];

    logic [15:0]      tol_reg;
    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rd_vld_reg;
    logic [BOX_W-1:0] rd_data_reg;
    logic             hit_reg;
    logic             out_vld_reg;
    out_item_t        out_reg;

    logic [BOX_W-1:0] item_box;
    logic             room;
    logic             match;

    function automatic logic near(input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] tol);
        logic [16:0] d;
        logic [16:0] m;
        d = {a[15], a} - {b[15], b};
        m = d[16] ? (17'd0 - d) : d;
        return m <= {1'b0, tol};
    endfunction

    assign item_box = {item_reg.corner1_x, item_reg.corner1_y,
                       item_reg.corner2_x, item_reg.corner2_y};
    assign room     = count_reg < CNT_W'(MAX_KEPT);
    assign match    = near(item_box[63:48], rd_data_reg[63:48], tol_reg)
                   && near(item_box[47:32], rd_data_reg[47:32], tol_reg)
                   && near(item_box[31:16], rd_data_reg[31:16], tol_reg)
                   && near(item_box[15:0],  rd_data_reg[15:0],  tol_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            // a new group empties the table
            if (cmd.latch && in_data.first_of_group)
                count_reg <= '0;
            else if (cmd.store_emit && room)
                count_reg <= count_reg + 1'b1;

            if (cmd.latch)
                idx_reg <= '0;
            else if (cmd.rd_en)
                idx_reg <= idx_reg + 1'b1;

            rd_vld_reg <= cmd.rd_en;

            if (cmd.latch)
                hit_reg <= 1'b0;
            else if (rd_vld_reg && match)
                hit_reg <= 1'b1;

            if (cmd.store_emit)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_emit && room)
            mem[count_reg[IDX_W-1:0]] <= item_box;
        if (cmd.rd_en)
            rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_emit)
        begin
            out_reg.out_corner1_x <= item_reg.corner1_x;
            out_reg.out_corner1_y <= item_reg.corner1_y;
            out_reg.out_corner2_x <= item_reg.corner2_x;
            out_reg.out_corner2_y <= item_reg.corner2_y;
            out_reg.out_class_id  <= item_reg.class_id;
            out_reg.not_stored    <= !room;
        end
    end

    assign status.count_zero  = (count_reg == '0);
    assign status.last_issued = (CNT_W'(idx_reg) + 1'b1 == count_reg);
    assign status.pipe_empty  = !rd_vld_reg;
    assign status.hit         = hit_reg;
    assign status.out_free    = !out_vld_reg || out_ready;

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond table size");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (CNT_W'(idx_reg) < count_reg))
        else $error("read of an entry outside the kept table");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_emit |-> (!out_vld_reg || out_ready))
        else $error("output register overwritten before transfer");
`endif

endmodule

// ===== src/box_duplicate_suppressor.sv =====
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data  (bds_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data (bds_pkg::out_item_t)
// cfg       input      cfg_wr_en              cfg_wr_data (match tolerance)
//
// An item takes one memory read per box kept in its group, plus latch, start, two drain
// steps and emit; a dropped item skips the emit step and goes straight back to idle.
// The first box of a group and a box on an empty table take only latch, start and emit.
// Reset clears the kept count and sets the tolerance to 5.0 pixels; no clearing pass.
// A stalled output holds its result; the next input transfer is taken meanwhile,
// and the block waits in its emit step only if a second result is ready first.
module box_duplicate_suppressor #(
    parameter int MAX_KEPT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  bds_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bds_pkg::out_item_t out_data
);
    import bds_pkg::*;

    bds_cmd_t    cmd;
    bds_status_t status;

    bds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bds_dpath #(
        .MAX_KEPT (MAX_KEPT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
